// ===== rtl/core/two_list_sorted_merge_macros.svh =====
// ----------------------------------------------------------------------------
// Two-list sorted merge: assertion macros
// Clocked on clk and disabled in rst; used by the files that carry checks.
// ----------------------------------------------------------------------------
`ifndef TWO_LIST_SORTED_MERGE_MACROS_SVH
`define TWO_LIST_SORTED_MERGE_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define TLSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define TLSM_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define TLSM_ASSERT(label, prop, msg)
`define TLSM_NEVER(label, expr, msg)
`endif

`endif

// ===== rtl/core/tlsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-list sorted merge: package
// Command codes, controller state type and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package tlsm_pkg;

  localparam int VALUE_W = 32;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

  typedef logic [CMD_W-1:0]          cmd_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_a;      // append request value to list A
    logic load_b;      // append request value to list B
    logic start_walk;  // rewind both read indexes
    logic step;        // capture the chosen head and advance its index
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic a_full;
    logic b_full;
    logic lists_empty;
    logic last;        // the head chosen now is the final one of the run
  } dp_status_t;

endpackage

// ===== rtl/core/tlsm_req_if.sv =====
// ----------------------------------------------------------------------------
// Two-list sorted merge: request channel
// Valid/ready channel carrying a command and a value.
// ----------------------------------------------------------------------------
interface tlsm_req_if import tlsm_pkg::*; ();
  logic   valid;
  logic   ready;
  cmd_t   cmd;
  value_t value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== rtl/core/tlsm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Two-list sorted merge: result channel
// Valid/ready channel carrying one merged value and its end-of-run mark.
// ----------------------------------------------------------------------------
interface tlsm_rsp_if import tlsm_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value_out;
  logic   is_last;

  modport source (output valid, output value_out, output is_last, input ready);
  modport sink   (input valid, input value_out, input is_last, output ready);
endinterface

// ===== rtl/core/tlsm_ram.sv =====
// ----------------------------------------------------------------------------
// Two-list sorted merge: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tlsm_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tlsm_datapath.sv =====
// ----------------------------------------------------------------------------
// Two-list sorted merge: datapath
// List stores, fill counts, read indexes, head compare and result register.
// ----------------------------------------------------------------------------
module tlsm_datapath import tlsm_pkg::*; #(
  parameter int LIST_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  value_t     in_value,
  output value_t     value_out,
  output logic       is_last
);

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [CNT_W-1:0] count_a, count_b;
  logic [CNT_W-1:0] idx_a, idx_b;
  logic [CNT_W-1:0] idx_a_next, idx_b_next;
  value_t           head_a, head_b;
  logic             a_avail, b_avail, take_a;

  tlsm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (cmd.load_a),
    .waddr (count_a[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (idx_a[ADDR_W-1:0]),
    .rdata (head_a)
  );

  tlsm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (cmd.load_b),
    .waddr (count_b[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (idx_b[ADDR_W-1:0]),
    .rdata (head_b)
  );

  // Ties go to A, which keeps the merge stable.
  always_comb begin
    a_avail    = idx_a < count_a;
    b_avail    = idx_b < count_b;
    take_a     = a_avail && (!b_avail || !(head_a > head_b));
    idx_a_next = idx_a + CNT_W'(take_a);
    idx_b_next = idx_b + CNT_W'(!take_a);
  end

  always_comb begin
    status.a_full      = count_a == CNT_W'(LIST_DEPTH);
    status.b_full      = count_b == CNT_W'(LIST_DEPTH);
    status.lists_empty = (count_a == '0) && (count_b == '0);
    status.last        = (idx_a_next == count_a) && (idx_b_next == count_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
    end else if (cmd.step && status.last) begin
      count_a <= '0;
      count_b <= '0;
    end else begin
      if (cmd.load_a) begin
        count_a <= count_a + CNT_W'(1);
      end
      if (cmd.load_b) begin
        count_b <= count_b + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      idx_a <= '0;
      idx_b <= '0;
    end else if (cmd.step) begin
      idx_a <= idx_a_next;
      idx_b <= idx_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      value_out <= take_a ? head_a : head_b;
      is_last   <= status.last;
    end
  end

endmodule

// ===== rtl/core/tlsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Two-list sorted merge: controller
// Takes requests while idle and paces the merge walk through a fetch and an
// emit state per result, holding while the result register is still occupied.
// ----------------------------------------------------------------------------
`include "two_list_sorted_merge_macros.svh"

module tlsm_ctrl import tlsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  cmd_t       in_cmd,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // Drop loads into a full list; ignore unused codes.
          unique case (in_cmd)
            CMD_LOAD_A: cmd.load_a = !status.a_full;
            CMD_LOAD_B: cmd.load_b = !status.b_full;
            CMD_START: begin
              if (!status.lists_empty) begin
                cmd.start_walk = 1'b1;
                state_next     = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        // Wait for the heads at the new indexes.
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.step   = 1'b1;
          state_next = status.last ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.step) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  `TLSM_NEVER(a_no_overwrite, cmd.step && out_valid && !out_ready, "result overwritten")
  `TLSM_ASSERT(a_fetch_then_emit, state == ST_FETCH |=> state == ST_EMIT, "fetch not followed")
  `TLSM_ASSERT(a_last_clears, cmd.step && status.last |=> status.lists_empty, "counts not cleared")
  `TLSM_NEVER(a_walk_empty, cmd.start_walk && status.lists_empty, "walk on empty lists")

endmodule

// ===== rtl/core/two_list_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// Two-list sorted merge: top level
// Merges two loaded ascending lists into one ascending result stream.
// ----------------------------------------------------------------------------
// Usage:
//   req carries cmd and value. Load A and load B append value to the chosen
//   list when taken; a load into a full list is taken and dropped.
//   Start walks both lists and sends count_a + count_b results on rsp, with
//   is_last set on the final one; ties take list A first. Both counts are
//   zero once the last result is formed. Start with both lists empty and the
//   unused command code are taken and do nothing.
//   Requests are taken only between merges. For each result the walk first
//   reads both list RAMs at the current indexes in the fetch state, then in
//   the emit state compares the heads and loads the result register.
//   While rsp stalls, the walk holds with the next heads ready; the block
//   returns to taking requests once the last result is in the register.
//   Reset (synchronous, rst high) empties both lists and clears rsp valid.
// ----------------------------------------------------------------------------
module two_list_sorted_merge import tlsm_pkg::*; #(
  parameter int LIST_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  tlsm_req_if.sink   req,
  tlsm_rsp_if.source rsp
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  tlsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_cmd    (req.cmd),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

  tlsm_datapath #(.LIST_DEPTH(LIST_DEPTH)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .status    (dp_status),
    .in_value  (req.value),
    .value_out (rsp.value_out),
    .is_last   (rsp.is_last)
  );

endmodule
